// File: hw/rtl/utf8v_pkg.sv
// Shared types and constants for the UTF-8 string validator.
// No dependencies; the RTL files refer to this package by scoped names, the bench files import it.
`timescale 1ns / 1ps

package utf8v_pkg;

    // Width of the running byte counter.
    localparam int COUNT_BITS = 8;
    // Compare width: holds count + 1 and the 8-bit length limit.
    localparam int CMP_W = (COUNT_BITS + 1 > 9) ? COUNT_BITS + 1 : 9;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [7:0] MAX_LENGTH_RST = 8'd128;
    localparam logic [7:0] BYTE_COUNT_MAX = 8'd255;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;
    localparam logic [7:0] ASCII_LIM = 8'h80;

    // Code point limits
    localparam logic [20:0] MIN_CP2   = 21'h00080;
    localparam logic [20:0] MIN_CP3   = 21'h00800;
    localparam logic [20:0] MIN_CP4   = 21'h10000;
    localparam logic [20:0] MAX_CP    = 21'h10ffff;
    localparam logic [20:0] SURR_LO   = 21'h0d800;
    localparam logic [20:0] SURR_HI   = 21'h0dfff;

    // Sequence length classes (continuation bytes that follow the lead)
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last;
    } utf8v_in_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] byte_count;
    } utf8v_out_t;

    // Per-string decode state
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [1:0]            pending;
        logic [20:0]           acc;
        logic [1:0]            seq_class;
        logic                  failed;
    } utf8v_state_t;

    localparam utf8v_state_t STATE_CLEAR = '0;

endpackage

// File: hw/rtl/utf8v_in_stage.sv
// Input register stage of the UTF-8 validator.
// Depends on utf8v_pkg for the input request type.
`timescale 1ns / 1ps

module utf8v_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utf8v_pkg::utf8v_in_t s_payload,
    input  logic                 take,
    output logic                 item_valid,
    output utf8v_pkg::utf8v_in_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    utf8v_pkg::utf8v_in_t item_reg;

    // Refill whenever the held request leaves or the stage is empty.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/utf8v_decode.sv
// Per-byte UTF-8 check: next string state and the verdict for one request.
// Pure combinational logic; depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_decode (
    input  utf8v_pkg::utf8v_state_t cur,
    input  utf8v_pkg::utf8v_in_t    item,
    input  logic [7:0]              max_length,
    output utf8v_pkg::utf8v_state_t nxt,
    output utf8v_pkg::utf8v_out_t   verdict
);

    logic [utf8v_pkg::CMP_W-1:0] count_inc;
    logic [utf8v_pkg::CMP_W-1:0] count_ext;
    logic [20:0]                 acc_shift;
    logic [20:0]                 cp_min;
    logic [7:0]                  b;
    utf8v_pkg::utf8v_state_t     upd;

    assign b         = item.data_byte;
    assign count_inc = utf8v_pkg::CMP_W'(cur.count) + utf8v_pkg::CMP_W'(1);
    assign acc_shift = {cur.acc[14:0], b[5:0]};

    always_comb begin
        case (cur.seq_class)
            utf8v_pkg::SEQ_TWO:   cp_min = utf8v_pkg::MIN_CP2;
            utf8v_pkg::SEQ_THREE: cp_min = utf8v_pkg::MIN_CP3;
            default:              cp_min = utf8v_pkg::MIN_CP4;
        endcase
    end

    always_comb begin
        upd = cur;
        if (item.has_byte) begin
            if (count_inc > utf8v_pkg::CMP_W'(max_length)) begin
                upd.failed = 1'b1;
            end
            if (!upd.failed) begin
                if (cur.pending == 2'd0) begin
                    if (b == 8'd0) begin
                        upd.failed = 1'b1;
                    end else if (b < utf8v_pkg::ASCII_LIM) begin
                        upd.failed = 1'b0;
                    end else if (b >= utf8v_pkg::LEAD2_LO && b <= utf8v_pkg::LEAD2_HI) begin
                        upd.acc       = 21'(b[4:0]);
                        upd.seq_class = utf8v_pkg::SEQ_TWO;
                        upd.pending   = 2'd1;
                    end else if (b >= utf8v_pkg::LEAD3_LO && b <= utf8v_pkg::LEAD3_HI) begin
                        upd.acc       = 21'(b[3:0]);
                        upd.seq_class = utf8v_pkg::SEQ_THREE;
                        upd.pending   = 2'd2;
                    end else if (b >= utf8v_pkg::LEAD4_LO && b <= utf8v_pkg::LEAD4_HI) begin
                        upd.acc       = 21'(b[2:0]);
                        upd.seq_class = utf8v_pkg::SEQ_FOUR;
                        upd.pending   = 2'd3;
                    end else begin
                        upd.failed = 1'b1;
                    end
                end else if (b[7:6] != 2'b10) begin
                    upd.failed = 1'b1;
                end else begin
                    upd.acc     = acc_shift;
                    upd.pending = cur.pending - 2'd1;
                    // Sequence complete: overlong, above range, or surrogate
                    if (cur.pending == 2'd1) begin
                        if (acc_shift < cp_min || acc_shift > utf8v_pkg::MAX_CP ||
                            (acc_shift >= utf8v_pkg::SURR_LO &&
                             acc_shift <= utf8v_pkg::SURR_HI)) begin
                            upd.failed = 1'b1;
                        end
                    end
                end
            end
            upd.count = (count_inc > utf8v_pkg::CMP_W'(utf8v_pkg::COUNT_MAX)) ?
                        utf8v_pkg::COUNT_MAX : count_inc[utf8v_pkg::COUNT_BITS-1:0];
        end
    end

    assign count_ext = utf8v_pkg::CMP_W'(upd.count);

    always_comb begin
        verdict.ok = !upd.failed && (upd.pending == 2'd0) && (upd.count != '0);
        verdict.byte_count = (count_ext > utf8v_pkg::CMP_W'(utf8v_pkg::BYTE_COUNT_MAX)) ?
                             utf8v_pkg::BYTE_COUNT_MAX : count_ext[7:0];
        nxt = item.last ? utf8v_pkg::STATE_CLEAR : upd;
    end

endmodule

// File: hw/rtl/utf8v_out_stage.sv
// Result register of the UTF-8 validator: holds one verdict until taken.
// Depends on utf8v_pkg for the result type.
`timescale 1ns / 1ps

module utf8v_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  utf8v_pkg::utf8v_out_t verdict,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8v_pkg::utf8v_out_t m_payload
);

    logic                  valid_reg;
    logic                  valid_next;
    utf8v_pkg::utf8v_out_t data_reg;

    assign room       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= verdict;
        end
    end

    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

endmodule

// File: hw/rtl/utf8_string_validator.sv
// UTF-8 string validator: a request passes the input register, then its verdict the m_ register.
// Throughput: one byte per cycle unless a last request waits for room; the string
// state register and utf8v_decode close a loop, and verdicts drain in parallel.
// Reset (aresetn low, synchronous): both stages empty, string state cleared,
// max_length back to 128. No clearing pass; ready in the first cycle after reset.
`timescale 1ns / 1ps

module utf8_string_validator (
    input  logic                  aclk,
    input  logic                  aresetn,
    // byte requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  utf8v_pkg::utf8v_in_t  s_payload,
    // verdicts, one per string
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8v_pkg::utf8v_out_t m_payload,
    // max_length register write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    logic                    item_valid;
    utf8v_pkg::utf8v_in_t    item;
    logic                    take;
    logic                    room;
    logic                    load;
    utf8v_pkg::utf8v_state_t state_reg;
    utf8v_pkg::utf8v_state_t state_next;
    utf8v_pkg::utf8v_out_t   verdict;
    logic [7:0]              max_length_reg;

    // Stage 1: the incoming request lands in a register.
    utf8v_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Stage 2: check the held byte against the running string state.
    utf8v_decode u_dec (
        .cur        (state_reg),
        .item       (item),
        .max_length (max_length_reg),
        .nxt        (state_next),
        .verdict    (verdict)
    );

    // A byte that does not end a string never waits; a last request needs
    // space in the verdict register (free now or emptied this cycle).
    assign take = item_valid && (!item.last || room);
    assign load = take && item.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= utf8v_pkg::STATE_CLEAR;
        end else if (take) begin
            state_reg <= state_next;
        end
    end

    // Length limit register; the user must write it only between strings, the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= utf8v_pkg::MAX_LENGTH_RST;
        end else if (cfg_valid) begin
            max_length_reg <= cfg_data;
        end
    end

    // Verdict register toward the consumer.
    utf8v_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .verdict   (verdict),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: hw/rtl/utf8v_checker.sv
// Port-level checks for utf8_string_validator, attached by bind.
// Depends on utf8v_pkg for the result type.
`timescale 1ns / 1ps

module utf8v_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input utf8v_pkg::utf8v_out_t m_payload
);

    // A stalled verdict keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("verdict changed while stalled");

    // A passing string has at least one byte.
    a_ok_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.ok |-> m_payload.byte_count != 8'd0)
        else $error("ok verdict with zero byte count");

    // Reset empties the verdict register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("verdict valid after reset");

endmodule

bind utf8_string_validator utf8v_checker u_chk (.*);

// File: tb/sv/utf8v_scoreboard_pkg.sv
// Verdict scoreboard for the UTF-8 string validator bench: predicts one verdict per string.
// Depends on utf8v_pkg for the request and verdict structs and the decode limits.
`timescale 1ns / 1ps

package utf8v_scoreboard_pkg;

    import utf8v_pkg::*;

    class verdict_scoreboard;
        logic [7:0]            max_len;
        logic [COUNT_BITS-1:0] byte_cnt;
        logic [1:0]            cont_left;
        logic [20:0]           code_point;
        logic [1:0]            seq_len;
        bit                    broken;
        utf8v_out_t            verdicts_due[$];
        int unsigned           failures;

        function new();
            max_len  = MAX_LENGTH_RST;
            failures = 0;
            clear_string();
        endfunction

        function void clear_string();
            byte_cnt   = '0;
            cont_left  = '0;
            code_point = '0;
            seq_len    = SEQ_NONE;
            broken     = 1'b0;
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction

        // One byte of UTF-8 decode; only called while the string is still clean.
        function void decode_byte(logic [7:0] b);
            logic [20:0] floor_cp;
            if (cont_left == 2'd0) begin
                if (b == 8'h00) begin
                    broken = 1'b1;
                end else if (b < ASCII_LIM) begin
                    // plain ASCII
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    code_point = {16'd0, b[4:0]};
                    seq_len    = SEQ_TWO;
                    cont_left  = 2'd1;
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    code_point = {17'd0, b[3:0]};
                    seq_len    = SEQ_THREE;
                    cont_left  = 2'd2;
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    code_point = {18'd0, b[2:0]};
                    seq_len    = SEQ_FOUR;
                    cont_left  = 2'd3;
                end else begin
                    broken = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                broken = 1'b1;
            end else begin
                code_point = {code_point[14:0], b[5:0]};
                cont_left  = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    case (seq_len)
                        SEQ_TWO:   floor_cp = MIN_CP2;
                        SEQ_THREE: floor_cp = MIN_CP3;
                        default:   floor_cp = MIN_CP4;
                    endcase
                    if (code_point < floor_cp || code_point > MAX_CP ||
                        (code_point >= SURR_LO && code_point <= SURR_HI))
                        broken = 1'b1;
                end
            end
        endfunction

        function void note_request(utf8v_in_t req);
            logic [COUNT_BITS:0] next_cnt;
            utf8v_out_t          v;
            if (req.has_byte) begin
                next_cnt = {1'b0, byte_cnt} + 1'b1;
                if (next_cnt > max_len)
                    broken = 1'b1;
                if (!broken)
                    decode_byte(req.data_byte);
                byte_cnt = (next_cnt > COUNT_MAX) ? COUNT_MAX : next_cnt[COUNT_BITS-1:0];
            end
            if (req.last) begin
                v.ok         = !broken && cont_left == 2'd0 && byte_cnt != '0;
                v.byte_count = (byte_cnt > BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : 8'(byte_cnt);
                verdicts_due.push_back(v);
                clear_string();
            end
        endfunction

        task report_mismatch(input string what);
            failures++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_verdict(utf8v_out_t got);
            utf8v_out_t exp;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict ok=%0b count=%0d with none due",
                                          got.ok, got.byte_count));
                return;
            end
            exp = verdicts_due.pop_front();
            if (got.ok !== exp.ok)
                report_mismatch($sformatf("ok got %0b want %0b", got.ok, exp.ok));
            if (got.byte_count !== exp.byte_count)
                report_mismatch($sformatf("byte_count got %0d want %0d",
                                          got.byte_count, exp.byte_count));
        endtask
    endclass

endpackage

// File: tb/sv/tb.sv
// Top-level bench for utf8_string_validator: directed strings, then random strings over
// several max_length settings, with random stalls on both channels. Needs utf8v_pkg and
// utf8v_scoreboard_pkg.
`timescale 1ns / 1ps

module tb;

    import utf8v_pkg::*;
    import utf8v_scoreboard_pkg::*;

    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 170;    // requests per phase, idle requests included
    localparam int DRAIN_CYCLES = 6;      // slack after the last verdict, for the block to go quiet
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {WELL_FORMED, BROKEN, NOISE, EMPTY_STRING} string_kind_t;
    typedef enum int {
        FLAW_NUL, FLAW_LEAD, FLAW_CONT, FLAW_OVERLONG, FLAW_SURROGATE, FLAW_ABOVE_MAX, FLAW_CUT
    } flaw_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    utf8v_in_t  s_payload = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    utf8v_out_t m_payload;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    verdict_scoreboard sb;

    logic [7:0]  str_bytes[$];          // string under construction
    logic [7:0]  max_len_now = MAX_LENGTH_RST;
    int unsigned items_sent  = 0;
    int unsigned cycles      = 0;
    bit          rush        = 1'b0;    // no gaps and no stalls while set
    bit          rush_phase  = 1'b0;

    utf8_string_validator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Watchdog. The slowest legal run is far below this.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Monitor: everything is sampled at the edge, before any of this step's
    // driver updates land, so the order of processes within the step does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_payload);
            if (m_valid && m_ready)
                sb.check_verdict(m_payload);
            if (cfg_valid && cfg_ready)
                sb.max_len = cfg_data;
        end
    end

    // Verdict side: one random stall per verdict, ready held high until it lands.
    initial begin
        int unsigned stall;
        wait (aresetn);
        forever begin
            stall = rush ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // One request on the byte channel. Valid is only dropped when a gap is
    // drawn, so back-to-back requests never lower and raise it in one step.
    task send_request(input utf8v_in_t req);
        int unsigned gap;
        gap = rush ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every verdict is back, then let the pipe empty out.
    // The first edge makes sure the monitor has already seen the last request.
    task drain_verdicts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task write_max_length(input logic [7:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        max_len_now  = v;
    endtask

    // Encodes cp into n bytes whether or not that is a legal encoding;
    // overlong and out-of-range cases come from here too.
    function automatic void push_code_point(input logic [20:0] cp, input int n);
        case (n)
            1: str_bytes.push_back(cp[7:0]);
            2: begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // A legal character of random length, often right on a range boundary.
    function automatic void push_valid_char();
        int unsigned r;
        int          n;
        bit          on_edge;
        logic [20:0] cp;
        r       = $urandom_range(0, 9);
        n       = (r < 4) ? 1 : (r < 6) ? 2 : (r < 8) ? 3 : 4;
        on_edge = ($urandom_range(0, 3) == 0);
        case (n)
            1: cp = on_edge ? ($urandom_range(0, 1) ? 21'h01 : 21'h7f)
                            : 21'($urandom_range(1, 'h7f));
            2: cp = on_edge ? ($urandom_range(0, 1) ? MIN_CP2 : 21'h7ff)
                            : 21'($urandom_range('h80, 'h7ff));
            3: begin
                if (on_edge) begin
                    case ($urandom_range(0, 3))
                        0:       cp = MIN_CP3;
                        1:       cp = SURR_LO - 1;
                        2:       cp = SURR_HI + 1;
                        default: cp = 21'hffff;
                    endcase
                end else begin
                    cp = 21'($urandom_range('h800, 'hffff));
                end
                // steer clear of the surrogate block
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp ^ 21'h4000;
            end
            default: cp = on_edge ? ($urandom_range(0, 1) ? MIN_CP4 : MAX_CP)
                                  : 21'($urandom_range('h10000, 'h10ffff));
        endcase
        push_code_point(cp, n);
    endfunction

    function automatic void push_flaw(input flaw_t flaw);
        int          n;
        logic [7:0]  b;
        logic [20:0] cp;
        n = $urandom_range(2, 4);
        case (flaw)
            FLAW_NUL: str_bytes.push_back(8'h00);
            FLAW_LEAD: begin
                // 80..C1 and F5..FF can never start a sequence
                do b = 8'($urandom_range('h80, 'hff)); while (b >= LEAD2_LO && b <= LEAD4_HI);
                str_bytes.push_back(b);
            end
            FLAW_CONT: begin
                case (n)
                    2:       str_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                    3:       str_bytes.push_back(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
                    default: str_bytes.push_back(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
                endcase
                repeat ($urandom_range(0, n - 2))
                    str_bytes.push_back({2'b10, 6'($urandom)});
                do b = 8'($urandom); while (b[7:6] == 2'b10);
                str_bytes.push_back(b);
            end
            FLAW_OVERLONG: begin
                cp = 21'((n == 2) ? $urandom_range(0, 'h7f)
                       : (n == 3) ? $urandom_range(0, 'h7ff) : $urandom_range(0, 'hffff));
                push_code_point(cp, n);
            end
            FLAW_SURROGATE: push_code_point(21'($urandom_range(SURR_LO, SURR_HI)), 3);
            FLAW_ABOVE_MAX: push_code_point(21'($urandom_range('h110000, 'h1fffff)), 4);
            default: begin
                // a legal character with its tail cut off
                cp = 21'((n == 2) ? $urandom_range('h80, 'h7ff)
                       : (n == 3) ? $urandom_range('he000, 'hffff)
                                  : $urandom_range('h10000, MAX_CP));
                push_code_point(cp, n);
                repeat ($urandom_range(1, n - 1)) void'(str_bytes.pop_back());
            end
        endcase
    endfunction

    function automatic void build_string(input string_kind_t kind, input int target);
        int    prefix;
        flaw_t flaw;
        str_bytes.delete();
        case (kind)
            WELL_FORMED: while (str_bytes.size() < target) push_valid_char();
            BROKEN: begin
                prefix = $urandom_range(0, target - 1);
                while (str_bytes.size() < prefix) push_valid_char();
                flaw = flaw_t'($urandom_range(FLAW_NUL, FLAW_CUT));
                push_flaw(flaw);
                // a cut-off character may end the string or run into the next lead
                if (flaw != FLAW_CUT || $urandom_range(0, 1))
                    while (str_bytes.size() < target) push_valid_char();
            end
            NOISE: repeat (target) str_bytes.push_back(8'($urandom));
            default: ;
        endcase
    endfunction

    // Sends the built string. The end mark rides on the last byte, or on a
    // separate request with no byte; an empty string is only that request.
    // Idle requests (no byte, no end) are sprinkled in and counted as well.
    task send_string(input bit end_on_marker);
        utf8v_in_t req;
        for (int i = 0; i < str_bytes.size(); i++) begin
            if ($urandom_range(0, 11) == 0) begin
                req.has_byte  = 1'b0;
                req.data_byte = 8'($urandom);
                req.last      = 1'b0;
                send_request(req);
                items_sent++;
            end
            req.has_byte  = 1'b1;
            req.data_byte = str_bytes[i];
            req.last      = (i == str_bytes.size() - 1) && !end_on_marker;
            send_request(req);
            items_sent++;
        end
        if (end_on_marker || str_bytes.size() == 0) begin
            req.has_byte  = 1'b0;
            req.data_byte = 8'($urandom);
            req.last      = 1'b1;
            send_request(req);
            items_sent++;
        end
    endtask

    task send_random_string();
        int unsigned  r;
        int unsigned  odds;
        int           target;
        int           lo;
        string_kind_t kind;
        r    = $urandom_range(0, 19);
        kind = (r < 12) ? WELL_FORMED : (r < 17) ? BROKEN : (r < 19) ? NOISE : EMPTY_STRING;
        // Mostly short strings; now and then one right around the length limit.
        // Long limits make those strings costly, so they come less often there.
        odds = (max_len_now <= 64) ? 10 : 40;
        if ($urandom_range(1, odds) == 1) begin
            lo     = (max_len_now > 2) ? max_len_now - 2 : 1;
            target = $urandom_range(lo, max_len_now + 2);
        end else begin
            target = $urandom_range(1, 16);
        end
        rush = rush_phase || ($urandom_range(0, 7) == 0);
        build_string(kind, target);
        send_string($urandom_range(0, 4) == 0);
    endtask

    initial begin
        utf8v_in_t   req;
        logic [7:0]  limit;
        int unsigned phase_start;

        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings at the reset limit of 128.
        str_bytes.delete();
        send_string(1'b0);                          // empty string
        req.has_byte  = 1'b0;
        req.data_byte = 8'ha5;
        req.last      = 1'b0;
        send_request(req);                          // idle request, no effect
        items_sent++;
        str_bytes = '{8'h7f};               send_string(1'b0);
        str_bytes = '{8'h00};               send_string(1'b0);    // NUL
        str_bytes = '{8'hff};               send_string(1'b0);    // bad lead
        str_bytes = '{8'hc2, 8'h80};        send_string(1'b0);    // smallest two-byte
        str_bytes = '{8'he0, 8'h80, 8'h80}; send_string(1'b0);    // overlong
        str_bytes = '{8'hed, 8'ha0, 8'h80}; send_string(1'b0);    // surrogate
        str_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_string(1'b0);  // above 10FFFF
        str_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; send_string(1'b0);  // exactly 10FFFF
        str_bytes = '{8'hc3};               send_string(1'b0);    // cut off at the end
        str_bytes = '{8'hc3, 8'h41};        send_string(1'b0);    // bad continuation
        str_bytes = '{8'h41};               send_string(1'b1);    // end on the no-byte request
        drain_verdicts();

        // Random phases, each with its own length limit; the register is only
        // written once the block has gone quiet.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       limit = 8'd255;
                1:       limit = 8'd1;
                2:       limit = 8'd2;
                4:       limit = 8'd16;
                6:       limit = 8'd254;
                7:       limit = MAX_LENGTH_RST;
                default: limit = 8'($urandom_range(3, 253));
            endcase
            write_max_length(limit);
            rush_phase  = (ph == 4);
            phase_start = items_sent;
            if (ph == 0) begin
                // runs the byte count into saturation
                rush = 1'b0;
                build_string(WELL_FORMED, $urandom_range(256, 300));
                send_string(1'b0);
            end
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_string();
            rush = 1'b0;
            drain_verdicts();
        end

        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/utf8v_pkg.sv
hw/rtl/utf8v_in_stage.sv
hw/rtl/utf8v_decode.sv
hw/rtl/utf8v_out_stage.sv
hw/rtl/utf8_string_validator.sv
hw/rtl/utf8v_checker.sv
tb/sv/utf8v_scoreboard_pkg.sv
tb/sv/tb.sv
